@@ rtl/core/rzb_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_pkg: shared types and constants of the rolling z-score band signal
// Field widths, fixed-point constants, register indexes and the job record
// passed from the front end to the back end.
// -----------------------------------------------------------------------------
package rzb_pkg;

    localparam int INSTRUMENTS_DEF = 16;
    localparam int WINDOW_MAX_DEF  = 256;
    localparam int PRICE_BITS_DEF  = 24;

    localparam int ID_W     = 4;
    localparam int PRICE_W  = 24;
    localparam int REGIME_W = 2;
    localparam int SCORE_W  = 16;
    localparam int CONF_W   = 16;
    localparam int WLEN_W   = 9;
    localparam int THR_W    = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Widest window count (WINDOW_MAX up to 1024) and the 64-bit sum lanes.
    localparam int N_W   = 11;
    localparam int SUM_W = 64;

    // Shared divider: 80-bit dividend, 64-bit divisor.
    localparam int DVD_W = 80;
    localparam int DVS_W = 64;

    localparam int Z_W       = 23;
    localparam int SCORE_M_W = 15;

    localparam logic [0:0] REG_WLEN = 1'b0;
    localparam logic [0:0] REG_THR  = 1'b1;

    localparam logic [WLEN_W-1:0] WLEN_RST = 9'd20;
    localparam logic [THR_W-1:0]  THR_RST  = 16'd512;

    localparam logic [REGIME_W-1:0] REGIME_MR    = 2'd0;
    localparam logic [REGIME_W-1:0] REGIME_TREND = 2'd1;

    localparam logic [CONF_W-1:0] CONF_MR    = 16'd51118;
    localparam logic [CONF_W-1:0] CONF_TREND = 16'd27525;
    localparam logic [CONF_W-1:0] CONF_OTHER = 16'd38011;

    localparam logic [Z_W-1:0]       Z_SAT     = 23'd8388607;
    localparam logic [SCORE_M_W-1:0] SCORE_SAT = 15'd32767;

    // floor(x/6) = (x * ceil(2^26/6)) >> 26, exact for x below 2^25.
    localparam int             RECIP_SH = 26;
    localparam int             RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP6 = 24'd11184811;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PRICE_W-1:0]  price;
        logic [REGIME_W-1:0] regime;
        logic [N_W-1:0]      n;
        logic [SUM_W-1:0]    s;
        logic [SUM_W-1:0]    s2;
    } t_job;

endpackage
`default_nettype wire

@@ rtl/core/rzb_if.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_if: bar and signal channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// -----------------------------------------------------------------------------
interface rzb_bar_if import rzb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     instrument_id;
    logic [PRICE_W-1:0]  close_price;
    logic [REGIME_W-1:0] market_regime;

    modport source (output valid, output instrument_id, output close_price,
                    output market_regime, input ready);
    modport sink   (input valid, input instrument_id, input close_price,
                    input market_regime, output ready);
endinterface

interface rzb_sig_if import rzb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ID_W-1:0]           signal_instrument;
    logic signed [SCORE_W-1:0] score;
    logic [CONF_W-1:0]         confidence;

    modport source (output valid, output signal_instrument, output score,
                    output confidence, input ready);
    modport sink   (input valid, input signal_instrument, input score,
                    input confidence, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rzb_ram.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module rzb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/rzb_div.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses when the quotient is complete.
// -----------------------------------------------------------------------------
module rzb_div import rzb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quot
);
    localparam int CW = $clog2(DVD_W);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic             r_done;

    logic [DVS_W:0] w_shift;
    logic           w_ge;

    assign w_shift = {r_rem[DVS_W-1:0], r_dvd[DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule
`default_nettype wire

@@ rtl/core/rzb_front.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_front: bar intake and rolling window update
// Accepts bars, updates the close ring and running sums of the instrument,
// and hands a job to the queue once the window is full.
// -----------------------------------------------------------------------------
module rzb_front import rzb_pkg::*; #(
    parameter int INSTRUMENTS = INSTRUMENTS_DEF,
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int PRICE_BITS  = PRICE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clear,
    input  wire logic [N_W-1:0] i_n,
    rzb_bar_if.sink             i_bar,
    output logic                o_push,
    output t_job                o_job,
    input  wire logic           i_full
);
    localparam int IW    = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int PSW   = $clog2(WINDOW_MAX);
    localparam int FW    = $clog2(WINDOW_MAX + 1);
    localparam int PW    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int SW    = PW + FW;
    localparam int S2W   = 2 * PW + FW;
    localparam int DEPTH = INSTRUMENTS * WINDOW_MAX;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_UPD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0] r_state;

    logic [FW-1:0]  r_fill [INSTRUMENTS];
    logic [PSW-1:0] r_pos  [INSTRUMENTS];
    logic [SW-1:0]  r_sum  [INSTRUMENTS];
    logic [S2W-1:0] r_sq   [INSTRUMENTS];

    logic [IW-1:0]       r_idx;
    logic [PW-1:0]       r_price;
    logic [REGIME_W-1:0] r_regime;
    logic [2*PW-1:0]     r_psq;
    logic [PSW-1:0]      r_pos_eff;
    logic [AW-1:0]       r_addr;
    logic                r_full;
    t_job                r_job;

    logic [FW-1:0]   w_n;
    logic [PSW-1:0]  w_pos_eff;
    logic [AW-1:0]   w_addr;
    logic [PW-1:0]   w_old;
    logic [2*PW-1:0] w_osq;
    logic [SW-1:0]   w_sum_new;
    logic [S2W-1:0]  w_sq_new;
    logic [FW-1:0]   w_fill_new;
    logic [FW-1:0]   w_pos_inc;
    logic [PSW-1:0]  w_pos_next;
    logic            w_accept;

    assign w_n       = FW'(i_n);
    assign w_pos_eff = (FW'(r_pos[r_idx]) >= w_n) ? '0 : r_pos[r_idx];
    assign w_addr    = AW'(AW'(r_idx) * AW'(WINDOW_MAX)) + AW'(w_pos_eff);
    assign w_osq     = (2 * PW)'(w_old) * (2 * PW)'(w_old);

    assign w_sum_new = r_sum[r_idx] - (r_full ? SW'(w_old) : '0) + SW'(r_price);
    assign w_sq_new  = r_sq[r_idx] - (r_full ? S2W'(w_osq) : '0) + S2W'(r_psq);
    assign w_fill_new = r_full ? r_fill[r_idx] : r_fill[r_idx] + 1'b1;
    assign w_pos_inc  = FW'(r_pos_eff) + 1'b1;
    assign w_pos_next = (w_pos_inc >= w_n) ? '0 : PSW'(w_pos_inc);

    assign i_bar.ready = (r_state == F_IDLE);
    assign w_accept    = i_bar.valid && i_bar.ready;

    rzb_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == F_UPD),
        .i_waddr (r_addr),
        .i_wdata (r_price),
        .i_raddr (w_addr),
        .o_rdata (w_old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            for (int i = 0; i < INSTRUMENTS; i++) begin
                r_fill[i] <= '0;
                r_pos[i]  <= '0;
                r_sum[i]  <= '0;
                r_sq[i]   <= '0;
            end
        end else begin
            if (i_clear) begin
                for (int i = 0; i < INSTRUMENTS; i++) begin
                    r_fill[i] <= '0;
                    r_pos[i]  <= '0;
                    r_sum[i]  <= '0;
                    r_sq[i]   <= '0;
                end
            end
            case (r_state)
                F_IDLE: begin
                    if (w_accept && (32'(i_bar.instrument_id) < INSTRUMENTS)) begin
                        r_state <= F_READ;
                    end
                end
                F_READ: begin
                    r_state <= F_UPD;
                end
                F_UPD: begin
                    r_fill[r_idx] <= w_fill_new;
                    r_pos[r_idx]  <= w_pos_next;
                    r_sum[r_idx]  <= w_sum_new;
                    r_sq[r_idx]   <= w_sq_new;
                    r_state       <= (w_fill_new >= w_n) ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx    <= IW'(i_bar.instrument_id);
            r_price  <= i_bar.close_price[PW-1:0];
            r_regime <= i_bar.market_regime;
        end
        if (r_state == F_READ) begin
            r_psq     <= (2 * PW)'(r_price) * (2 * PW)'(r_price);
            r_pos_eff <= w_pos_eff;
            r_addr    <= w_addr;
            r_full    <= r_fill[r_idx] >= w_n;
        end
        if (r_state == F_UPD) begin
            r_job.id     <= ID_W'(r_idx);
            r_job.price  <= PRICE_W'(r_price);
            r_job.regime <= r_regime;
            r_job.n      <= N_W'(w_n);
            r_job.s      <= SUM_W'(w_sum_new);
            r_job.s2     <= SUM_W'(w_sq_new);
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;
endmodule
`default_nettype wire

@@ rtl/core/rzb_queue.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_queue: short job queue
// Small FIFO between the window update and the statistics engine.
// -----------------------------------------------------------------------------
module rzb_queue import rzb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);
    localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CTW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_mem [QUEUE_DEPTH];
    logic [PTW-1:0] r_wptr;
    logic [PTW-1:0] r_rptr;
    logic [CTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CTW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/rzb_back.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_back: statistics engine
// Variance, square root, z-score and band test of one job at a time,
// with the result held in an output register.
// -----------------------------------------------------------------------------
module rzb_back import rzb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire t_job             i_job,
    output logic                  o_pop,
    input  wire logic [THR_W-1:0] i_thr,
    rzb_sig_if.source             o_sig
);
    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_MUL    = 4'd1;
    localparam logic [3:0] B_Q      = 4'd2;
    localparam logic [3:0] B_DIV1   = 4'd3;
    localparam logic [3:0] B_SQRT   = 4'd4;
    localparam logic [3:0] B_NSIG   = 4'd5;
    localparam logic [3:0] B_DSTART = 4'd6;
    localparam logic [3:0] B_DIV2   = 4'd7;
    localparam logic [3:0] B_CMP    = 4'd8;
    localparam logic [3:0] B_OUT    = 4'd9;

    localparam int PROD_W = Z_W + RECIP_W;
    localparam int SM_W   = PROD_W - RECIP_SH;
    localparam int HALF   = SUM_W / 2;

    logic [3:0] r_state;
    t_job       r_job;

    logic [SUM_W-1:0]  r_ns2;
    logic [SUM_W-1:0]  r_ss;
    logic [HALF-1:0]   r_cross;
    logic [SUM_W-1:0]  r_np;
    logic [DVS_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_mag;
    logic              r_neg;
    logic [SUM_W-1:0]  r_var;
    logic [SUM_W-1:0]  r_res;
    logic [SUM_W-1:0]  r_bit;
    logic [DVS_W-1:0]  r_nsig;
    logic [Z_W-1:0]    r_zmag;
    logic [PROD_W-1:0] r_prod;

    logic               r_ovalid;
    logic [ID_W-1:0]    r_oid;
    logic [SCORE_W-1:0] r_oscore;
    logic [CONF_W-1:0]  r_oconf;

    logic [SUM_W-1:0]     w_q;
    logic [SUM_W-1:0]     w_trial;
    logic                 w_take;
    logic [31:0]          w_sig;
    logic                 w_zsat;
    logic                 w_start;
    logic [DVD_W-1:0]     w_dvd;
    logic [DVS_W-1:0]     w_dvs;
    logic                 w_done;
    logic [DVD_W-1:0]     w_quot;
    logic [SM_W-1:0]      w_sm;
    logic [SCORE_M_W-1:0] w_smc;
    logic [CONF_W-1:0]    w_conf;
    logic                 w_oslot;

    // The square of the sum is built from its halves: the low half squared
    // plus twice the cross product moved up by one half, modulo 2^64.
    assign w_q     = r_ns2 - r_ss - {r_cross[HALF-2:0], {(HALF + 1){1'b0}}};
    assign w_trial = r_res + r_bit;
    assign w_take  = r_var >= w_trial;
    assign w_sig   = (r_res[31:0] == '0) ? 32'd1 : r_res[31:0];
    assign w_zsat  = r_mag[SUM_W-1:40] != '0;

    // The divider serves both the variance and the z-score division.
    assign w_start = ((r_state == B_Q) && (w_q != '0)) ||
                     ((r_state == B_DSTART) && !w_zsat);
    assign w_dvd   = (r_state == B_Q) ? {w_q, 16'd0} : {r_mag[55:0], 24'd0};
    assign w_dvs   = (r_state == B_Q) ? r_den : r_nsig;

    rzb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    assign w_sm  = r_prod[PROD_W-1:RECIP_SH];
    assign w_smc = (w_sm > SM_W'(SCORE_SAT)) ? SCORE_SAT : w_sm[SCORE_M_W-1:0];

    always_comb begin
        case (r_job.regime)
            REGIME_MR:    w_conf = CONF_MR;
            REGIME_TREND: w_conf = CONF_TREND;
            default:      w_conf = CONF_OTHER;
        endcase
    end

    assign w_oslot = !r_ovalid || o_sig.ready;
    assign o_pop   = (r_state == B_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_sig.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_state <= B_Q;
                end
                B_Q: begin
                    r_state <= (w_q == '0) ? B_IDLE : B_DIV1;
                end
                B_DIV1: begin
                    if (w_done) begin
                        r_state <= B_SQRT;
                    end
                end
                B_SQRT: begin
                    if (r_bit == SUM_W'(1)) begin
                        r_state <= B_NSIG;
                    end
                end
                B_NSIG: begin
                    r_state <= B_DSTART;
                end
                B_DSTART: begin
                    r_state <= w_zsat ? B_CMP : B_DIV2;
                end
                B_DIV2: begin
                    if (w_done) begin
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    r_state <= ({1'b0, r_zmag} >= {i_thr, 8'd0}) ? B_OUT : B_IDLE;
                end
                B_OUT: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_state  <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
            end
            B_MUL: begin
                r_ns2   <= SUM_W'(r_job.n * r_job.s2);
                r_ss    <= SUM_W'(r_job.s[HALF-1:0]) * SUM_W'(r_job.s[HALF-1:0]);
                r_cross <= HALF'(r_job.s[HALF-1:0] * r_job.s[SUM_W-1:HALF]);
                r_np    <= SUM_W'(SUM_W'(r_job.n) * SUM_W'(r_job.price));
                r_den   <= DVS_W'(DVS_W'(r_job.n) * DVS_W'(r_job.n - 1'b1));
            end
            B_Q: begin
                r_neg <= r_np < r_job.s;
                r_mag <= (r_np >= r_job.s) ? (r_np - r_job.s) : (r_job.s - r_np);
            end
            B_DIV1: begin
                r_var <= (w_quot[DVD_W-1:SUM_W] != '0) ? '1 : w_quot[SUM_W-1:0];
                r_res <= '0;
                r_bit <= SUM_W'(1) << (SUM_W - 2);
            end
            B_SQRT: begin
                if (w_take) begin
                    r_var <= r_var - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            B_NSIG: begin
                r_nsig <= DVS_W'(DVS_W'(r_job.n) * DVS_W'(w_sig));
            end
            B_DSTART: begin
                if (w_zsat) begin
                    r_zmag <= Z_SAT;
                end
            end
            B_DIV2: begin
                if (w_done) begin
                    r_zmag <= (w_quot > DVD_W'(Z_SAT)) ? Z_SAT : w_quot[Z_W-1:0];
                end
            end
            B_CMP: begin
                r_prod <= PROD_W'(r_zmag) * PROD_W'(RECIP6);
            end
            B_OUT: begin
                if (w_oslot) begin
                    r_oid    <= r_job.id;
                    r_oscore <= r_neg ? {1'b0, w_smc} : SCORE_W'(17'd0 - {2'b0, w_smc});
                    r_oconf  <= w_conf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sig.valid             = r_ovalid;
    assign o_sig.signal_instrument = r_oid;
    assign o_sig.score             = r_oscore;
    assign o_sig.confidence        = r_oconf;
endmodule
`default_nettype wire

@@ rtl/core/rolling_zscore_band_signal.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// Flow: the front end queues a job for each full-window bar; the back end then runs
//   up to two divisions on the shared serial divider and a 32-step square root.
// Throughput: set by the shared serial divider and square-root loop; the front end
//   runs ahead by up to three jobs.
// Reset: synchronous, active low; clears counts, positions and sums of every
//   instrument and loads the register defaults. The close ring is not cleared.
// -----------------------------------------------------------------------------
// rolling_zscore_band_signal: rolling Bollinger z-score band signal
// Per-instrument rolling window of closes with a z-score band trigger.
// -----------------------------------------------------------------------------
module rolling_zscore_band_signal import rzb_pkg::*; #(
    parameter int INSTRUMENTS = INSTRUMENTS_DEF,
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int PRICE_BITS  = PRICE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    rzb_bar_if.sink                 i_bar,
    rzb_sig_if.source               o_sig,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);
    // Configuration registers. A write to the window length restarts the
    // history of every instrument, so the front end clears its counters.
    logic [WLEN_W-1:0] r_wlen;
    logic [THR_W-1:0]  r_thr;
    logic              w_wr;
    logic              w_clear;
    logic [N_W-1:0]    w_n;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign w_clear = w_wr && (paddr[2] == REG_WLEN);
    assign prdata  = (paddr[2] == REG_THR) ? PDATA_W'(r_thr) : PDATA_W'(r_wlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RST;
            r_thr  <= THR_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_WLEN) begin
                r_wlen <= pwdata[WLEN_W-1:0];
            end else begin
                r_thr <= pwdata[THR_W-1:0];
            end
        end
    end

    // Effective window: the register value held within three and the ring
    // depth of one instrument.
    always_comb begin
        if (r_wlen < WLEN_W'(3)) begin
            w_n = N_W'(3);
        end else if (32'(r_wlen) > WINDOW_MAX) begin
            w_n = N_W'(WINDOW_MAX);
        end else begin
            w_n = N_W'(r_wlen);
        end
    end

    // The front end owns the ring and running sums; each full window yields
    // one job for the back end, which does the slow arithmetic.
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    rzb_front #(
        .INSTRUMENTS (INSTRUMENTS),
        .WINDOW_MAX  (WINDOW_MAX),
        .PRICE_BITS  (PRICE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_n     (w_n),
        .i_bar   (i_bar),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_full  (w_full)
    );

    rzb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    // The back end holds its result in an output register, so a stalled
    // signal transfer does not stop the next job from being worked on.
    rzb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .i_thr   (r_thr),
        .o_sig   (o_sig)
    );
endmodule
`default_nettype wire

@@ rtl/core/rzb_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rzb_checker: port-level checks of the band signal block
// Watches the signal channel and the configuration port.
// -----------------------------------------------------------------------------
module rzb_checker import rzb_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      i_ready,
    input wire logic signed [SCORE_W-1:0] i_score,
    input wire logic [CONF_W-1:0]         i_conf,
    input wire logic                      i_pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("signal dropped before transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("signal valid after reset");

    a_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_conf == CONF_MR || i_conf == CONF_TREND || i_conf == CONF_OTHER))
        else $error("confidence is not a regime value");

    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_score != 16'sh8000))
        else $error("score outside clamp range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("configuration port not ready");
endmodule

bind rolling_zscore_band_signal rzb_checker u_rzb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_sig.valid),
    .i_ready  (o_sig.ready),
    .i_score  (o_sig.score),
    .i_conf   (o_sig.confidence),
    .i_pready (pready)
);
`default_nettype wire

@@ sim/tb_rolling_zscore_band_signal.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// tb_rolling_zscore_band_signal: self-checking bench of the z-score band signal
// Bars are driven with random gaps and signals are taken with random stalls.
// A predictor tracks every instrument's window and sums, and each signal
// transfer is compared field by field with the oldest predicted signal.
// -----------------------------------------------------------------------------
module tb_rolling_zscore_band_signal;
    import rzb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    // Each job passes through the serial divider and square-root loop, and the block can
    // hold four jobs at once (front end, two queued, back end), so this covers jobs that
    // raise no signal while the bench believed the block was idle.
    localparam int SETTLE_CYCLES = 1000;
    localparam int WIN_CAP = 256;
    localparam int NUM_INST = 16;
    localparam logic [PADDR_W-1:0] ADDR_WLEN = {REG_WLEN, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_THR  = {REG_THR, 2'b00};
    localparam logic [REGIME_W-1:0] REGIME_OTHER = 2'd2;
    localparam logic [REGIME_W-1:0] REGIME_SPARE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]           inst;
        logic signed [SCORE_W-1:0] score;
        logic [CONF_W-1:0]         conf;
    } t_signal;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    rzb_bar_if bar ();
    rzb_sig_if sig ();

    rolling_zscore_band_signal dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bar   (bar),
        .o_sig   (sig),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: one window of closes per instrument plus the sums.
    logic [PRICE_W-1:0] close_hist [NUM_INST][WIN_CAP];
    int unsigned        hist_fill [NUM_INST];
    int unsigned        hist_pos [NUM_INST];
    bit [63:0]          close_sum [NUM_INST];
    bit [63:0]          close_sq_sum [NUM_INST];
    logic [WLEN_W-1:0]  win_setting;
    logic [THR_W-1:0]   thr_setting;
    longint             price_base [NUM_INST];

    t_signal     pending_signals [$];
    int unsigned mismatches;
    int unsigned signals_seen;
    int unsigned bars_sent;
    int unsigned cycle_count;
    int unsigned hold_ticks;
    int unsigned stall_left;
    bit          steady_flow;

    // Clock and watchdog.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d signals outstanding",
                     cycle_count, pending_signals.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: ready drops for random stretches, mostly short and sometimes
    // long. A hold request from a test forces one very long stretch.
    initial begin
        sig.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_ticks > 0) begin
                sig.ready <= 1'b0;
                hold_ticks = hold_ticks - 1;
            end else if (stall_left > 0) begin
                sig.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                sig.ready <= 1'b1;
                if (!steady_flow) begin
                    if ($urandom_range(0, 399) == 0)
                        stall_left = $urandom_range(50, 400);
                    else if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 4);
                end
            end
        end
    end

    // Every signal transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_signal want;
        if (i_rst_n && sig.valid && sig.ready) begin
            signals_seen <= signals_seen + 1;
            if (pending_signals.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected signal inst=%0d score=%0d conf=%0d",
                             sig.signal_instrument, sig.score, sig.confidence);
            end else begin
                want = pending_signals[0];
                pending_signals.delete(0);
                if (sig.signal_instrument !== want.inst || sig.score !== want.score
                        || sig.confidence !== want.conf) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"signal mismatch: expected inst=%0d score=%0d conf=%0d,",
                                  " got inst=%0d score=%0d conf=%0d"},
                                 want.inst, want.score, want.conf,
                                 sig.signal_instrument, sig.score, sig.confidence);
                end
            end
        end
    end

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic void clear_windows();
        for (int i = 0; i < NUM_INST; i++) begin
            hist_fill[i] = 0;
            hist_pos[i] = 0;
            close_sum[i] = 0;
            close_sq_sum[i] = 0;
        end
    endfunction

    // Updates the instrument's window with one close and queues the signal
    // that the bar should raise, if any.
    function automatic void predict_signal(logic [ID_W-1:0] inst, logic [PRICE_W-1:0] close,
                                           logic [REGIME_W-1:0] regime);
        bit [63:0] n, pos, px, old, s, q, den, vi, vr, var_q16, sigma, np, mag, zmag, sm;
        bit        below;
        t_signal   sgl;
        n = (win_setting < 3) ? 3 : ((win_setting > WIN_CAP) ? WIN_CAP : win_setting);
        pos = hist_pos[inst];
        if (pos >= n) pos = 0;
        px = close;
        if (hist_fill[inst] >= n) begin
            old = close_hist[inst][pos];
            close_sum[inst] = close_sum[inst] - old;
            close_sq_sum[inst] = close_sq_sum[inst] - old * old;
        end
        close_hist[inst][pos] = close;
        close_sum[inst] = close_sum[inst] + px;
        close_sq_sum[inst] = close_sq_sum[inst] + px * px;
        pos = pos + 1;
        if (pos >= n) pos = 0;
        hist_pos[inst] = pos;
        if (hist_fill[inst] < n) hist_fill[inst] = hist_fill[inst] + 1;
        if (hist_fill[inst] < n) return;

        s = close_sum[inst];
        q = n * close_sq_sum[inst] - s * s;
        // A flat window has no spread and raises nothing.
        if (q == 0) return;
        den = n * (n - 1);
        vi = q / den;
        vr = q % den;
        if (vi > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) var_q16 = 64'hFFFF_FFFF_FFFF_FFFF;
        else var_q16 = (vi << 16) + ((vr << 16) / den);
        sigma = int_sqrt(var_q16);
        if (sigma == 0) sigma = 1;
        np = n * px;
        below = (np < s);
        mag = below ? s - np : np - s;
        if (mag > (64'hFFFF_FFFF_FFFF_FFFF >> 24)) zmag = Z_SAT;
        else zmag = (mag << 24) / (n * sigma);
        if (zmag > Z_SAT) zmag = Z_SAT;
        if (zmag < ({48'd0, thr_setting} << 8)) return;
        sm = zmag / 6;
        if (sm > SCORE_SAT) sm = SCORE_SAT;
        sgl.inst = inst;
        // A close below the mean gives a positive score.
        sgl.score = below ? sm[15:0] : -sm[15:0];
        sgl.conf = (regime == REGIME_MR) ? CONF_MR
                 : ((regime == REGIME_TREND) ? CONF_TREND : CONF_OTHER);
        pending_signals.insert(pending_signals.size(), sgl);
    endfunction

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WLEN) begin
            win_setting = data[WLEN_W-1:0];
            clear_windows();
        end else begin
            thr_setting = data[THR_W-1:0];
        end
    endtask

    task automatic wait_drained();
        while (pending_signals.size() != 0) @(posedge i_clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_registers(int unsigned wlen, int unsigned thr);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(ADDR_WLEN, wlen);
        apb_write(ADDR_THR, thr);
    endtask

    // Offers one bar after a random gap and returns once it is transferred.
    task automatic send_bar(logic [ID_W-1:0] inst, logic [PRICE_W-1:0] close,
                            logic [REGIME_W-1:0] regime);
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        gap = 0;
        if (!steady_flow) begin
            if (pick < 3) gap = $urandom_range(30, 300);
            else if (pick < 40) gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            bar.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bar.valid <= 1'b1;
        bar.instrument_id <= inst;
        bar.close_price <= close;
        bar.market_regime <= regime;
        do @(posedge i_clk); while (!bar.ready);
        predict_signal(inst, close, regime);
        bars_sent = bars_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic park_bar_channel();
        bar.valid <= 1'b0;
    endtask

    // Closes mostly wander around a per-instrument level, with rare spikes
    // and occasional values from anywhere in the price range.
    function automatic logic [PRICE_W-1:0] next_close(int unsigned inst, int unsigned spread);
        longint p;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return PRICE_W'($urandom());
        if (pick < 9) p = price_base[inst] + ($urandom_range(0, 1) ? 8 : -8) * longint'(spread);
        else p = price_base[inst] + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        if (p < 0) p = 0;
        if (p > 24'hFFFFFF) p = 24'hFFFFFF;
        return p[PRICE_W-1:0];
    endfunction

    task automatic random_bars(int unsigned count, int unsigned last_inst,
                               int unsigned spread);
        int unsigned inst;
        for (int k = 0; k < count; k++) begin
            inst = $urandom_range(0, last_inst);
            send_bar(ID_W'(inst), next_close(inst, spread), REGIME_W'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_directed();
        set_registers(3, 0);
        // Price extremes on one instrument.
        send_bar(4'd0, 24'd0, REGIME_MR);
        send_bar(4'd0, 24'hFFFFFF, REGIME_TREND);
        send_bar(4'd0, 24'd0, REGIME_OTHER);
        send_bar(4'd0, 24'hFFFFFF, REGIME_SPARE);
        send_bar(4'd0, 24'hFFFFFF, REGIME_MR);
        // A flat window raises nothing.
        send_bar(4'd1, 24'd5, REGIME_MR);
        send_bar(4'd1, 24'd5, REGIME_MR);
        send_bar(4'd1, 24'd5, REGIME_MR);
        send_bar(4'd1, 24'd5, REGIME_TREND);
        // Every regime code, including the spare one.
        send_bar(4'd2, 24'd10, REGIME_MR);
        send_bar(4'd2, 24'd20, REGIME_MR);
        send_bar(4'd2, 24'd30, REGIME_MR);
        send_bar(4'd2, 24'd40, REGIME_TREND);
        send_bar(4'd2, 24'd5, REGIME_OTHER);
        send_bar(4'd2, 24'd90, REGIME_SPARE);
        // Highest instrument, tiny spread then a jump.
        send_bar(4'd15, 24'd1, REGIME_MR);
        send_bar(4'd15, 24'd2, REGIME_MR);
        send_bar(4'd15, 24'd1000000, REGIME_TREND);
        send_bar(4'd15, 24'h800000, REGIME_OTHER);
        send_bar(4'd15, 24'h7FFFFF, REGIME_SPARE);
        park_bar_channel();
    endtask

    task automatic test_default_window();
        set_registers(20, 512);
        random_bars(400, 3, 200);
        park_bar_channel();
    endtask

    task automatic test_narrow_window();
        set_registers(3, 256);
        steady_flow = 1'b1;
        random_bars(150, 15, 50);
        steady_flow = 1'b0;
        random_bars(250, 15, 5000);
        park_bar_channel();
    endtask

    // A zero window setting clamps to three and the top threshold is never met.
    task automatic test_silent_threshold();
        set_registers(0, 65535);
        random_bars(100, 15, 1000);
        park_bar_channel();
    endtask

    // The largest setting clamps to the deepest window, which then wraps.
    task automatic test_full_window();
        set_registers(511, 0);
        random_bars(300, 0, 3000);
        park_bar_channel();
    endtask

    // The receiver holds off long enough for the block to fill and stall.
    task automatic test_backpressure();
        set_registers($urandom_range(4, 40), $urandom_range(0, 1024));
        hold_ticks = 4000;
        random_bars(250, 7, 400);
        park_bar_channel();
        set_registers($urandom_range(4, 40), $urandom_range(0, 1024));
        random_bars(250, 7, 400);
        park_bar_channel();
    endtask

    // The sender stops until every pending signal has arrived, then resumes.
    task automatic test_sender_pause();
        set_registers(5, $urandom_range(0, 700));
        random_bars(115, 5, 800);
        park_bar_channel();
        wait_drained();
        @(negedge i_clk);
        random_bars(115, 5, 800);
        park_bar_channel();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bar.valid = 1'b0;
        bar.instrument_id = '0;
        bar.close_price = '0;
        bar.market_regime = '0;
        mismatches = 0;
        signals_seen = 0;
        bars_sent = 0;
        cycle_count = 0;
        hold_ticks = 0;
        steady_flow = 1'b0;
        win_setting = WLEN_RST;
        thr_setting = THR_RST;
        clear_windows();
        for (int i = 0; i < NUM_INST; i++) begin
            case (i % 4)
                0: price_base[i] = $urandom_range(0, 2000);
                1: price_base[i] = 24'hFFFFFF - $urandom_range(0, 2000);
                default: price_base[i] = $urandom_range(0, 24'hFFFFFF);
            endcase
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_default_window();
        test_narrow_window();
        test_silent_threshold();
        test_full_window();
        test_backpressure();
        test_sender_pause();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("bars sent: %0d, signals checked: %0d, mismatches: %0d",
                 bars_sent, signals_seen, mismatches);
        $display("windows 3 to 256 with clamping, thresholds 0 to 65535, all regimes");
        if (mismatches == 0 && pending_signals.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/rzb_pkg.sv
rtl/core/rzb_if.sv
rtl/core/rzb_ram.sv
rtl/core/rzb_div.sv
rtl/core/rzb_front.sv
rtl/core/rzb_queue.sv
rtl/core/rzb_back.sv
rtl/core/rolling_zscore_band_signal.sv
rtl/core/rzb_checker.sv
sim/tb_rolling_zscore_band_signal.sv
